@@ hw/rtl/ggnh_pkg.sv @@
// shared types and codes of the greedy geographic next-hop engine
// no dependencies; imported by the top level
`timescale 1ns / 1ps
`default_nettype none

package ggnh_pkg;

    localparam logic [15:0] ADDR_BCAST = 16'hFFFF;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_X  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_Y  = 2'd2;

    // input word actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_ROUTE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_FWD     = 2'd0;
    localparam logic [1:0] ST_BADADDR = 2'd1;
    localparam logic [1:0] ST_NOROUTE = 2'd2;
    localparam logic [1:0] ST_WRITTEN = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        RES_WRITE   = 2'd0,
        RES_BADADDR = 2'd1,
        RES_ROUTE   = 2'd2
    } res_kind_t;

    // what a point in the distance pipeline stands for
    typedef enum logic [1:0] {
        PT_OWN   = 2'd0,
        PT_FACE  = 2'd1,
        PT_ENTRY = 2'd2
    } pt_kind_t;

    typedef struct packed {
        logic     vld;
        pt_kind_t kind;
        logic     last;
    } tag_t;

endpackage

`default_nettype wire

@@ hw/rtl/ggnh_ram.sv @@
// generic single-port-write ram with one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ggnh_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                    wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/greedy_geographic_next_hop_top.sv @@
// greedy geographic next-hop engine: neighbor table in ggnh_ram plus scan pipeline
// depends on ggnh_pkg and ggnh_ram
//
// usage
//   s_ channel takes one word per item: action 0 writes a neighbor slot,
//   action 1 routes a packet. m_ channel returns one result word per item.
//   configuration (own id and coordinates) is written through cfg_we /
//   cfg_index / cfg_wdata while the block is idle.
// timing
//   write item or route with unknown destination: idle, then the finish state.
//   route item: idle, scan, then finish; a new item is taken only in idle; the
//   table ram is read one entry per cycle, after this node's and the face
//   start's distances pass the same diff / square / sum pipeline.
// reset
//   aresetn (synchronous, low) clears the per-entry valid bits, so every
//   slot reads as an empty, non-bidirectional entry; state to idle, control regs to 0.
// stall
//   a finished result waits in the output register while the next item is
//   accepted and worked on; a later result waits in the finish state until
//   the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module greedy_geographic_next_hop_top
    import ggnh_pkg::*;
#(
    parameter int NEIGHBORS  = 16,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    // configuration
    input  wire logic                                          cfg_we,
    input  wire logic [CFG_IDX_W-1:0]                          cfg_index,
    input  wire logic [(COORD_BITS > 16 ? COORD_BITS : 16)-1:0] cfg_wdata,
    // input words
    input  wire logic                                          s_valid,
    output logic                                               s_ready,
    input  wire logic                                          s_action,
    input  wire logic [3:0]                                    s_slot,
    input  wire logic [15:0]                                   s_node_id,
    input  wire logic                                          s_link_bidir,
    input  wire logic                                          s_coord_known,
    input  wire logic signed [COORD_BITS-1:0]                  s_coord_x,
    input  wire logic signed [COORD_BITS-1:0]                  s_coord_y,
    input  wire logic [15:0]                                   s_face_start_id,
    input  wire logic signed [COORD_BITS-1:0]                  s_face_x,
    input  wire logic signed [COORD_BITS-1:0]                  s_face_y,
    // result words
    output logic                                               m_valid,
    input  wire logic                                          m_ready,
    output logic [1:0]                                         m_status,
    output logic [15:0]                                        m_next_hop,
    output logic [15:0]                                        m_face_start_out
);

    localparam int IDX_W  = NEIGHBORS > 1 ? $clog2(NEIGHBORS) : 1;
    localparam int FEED_W = $clog2(NEIGHBORS + 2);
    localparam int ABS_W  = COORD_BITS + 1;
    localparam int DIST_W = 2 * COORD_BITS + 2;

    typedef struct packed {
        logic [15:0]                   id;
        logic                          bidir;
        logic                          known;
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

    // ---------------- configuration ----------------
    logic [15:0]                  own_id_reg;
    logic signed [COORD_BITS-1:0] own_x_reg;
    logic signed [COORD_BITS-1:0] own_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg <= '0;
            own_x_reg  <= '0;
            own_y_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_OWN_ID: own_id_reg <= cfg_wdata[15:0];
                CFG_OWN_X:  own_x_reg  <= cfg_wdata[COORD_BITS-1:0];
                CFG_OWN_Y:  own_y_reg  <= cfg_wdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- control ----------------
    state_t    state_reg, state_next;
    res_kind_t res_kind_reg;
    logic      in_acc;
    logic      out_load;

    // latched route word
    logic [15:0]                  dst_id_reg;
    logic signed [COORD_BITS-1:0] dst_x_reg;
    logic signed [COORD_BITS-1:0] dst_y_reg;
    logic [15:0]                  face_id_reg;
    logic signed [COORD_BITS-1:0] face_x_reg;
    logic signed [COORD_BITS-1:0] face_y_reg;

    assign s_ready  = (state_reg == S_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign out_load = (state_reg == S_FINISH) && (!m_valid || m_ready);

    // ---------------- table write ----------------
    logic [IDX_W+3:0]     slot_wide;
    logic                 slot_in_range;
    logic                 tbl_we;
    logic [IDX_W-1:0]     tbl_waddr;
    entry_t               wr_ent;
    logic [NEIGHBORS-1:0] vbits_reg;

    assign slot_wide     = (IDX_W + 4)'(s_slot);
    assign slot_in_range = slot_wide < (IDX_W + 4)'(NEIGHBORS);
    assign tbl_we        = in_acc && (s_action == ACT_WRITE) && slot_in_range;
    assign tbl_waddr     = slot_wide[IDX_W-1:0];
    assign wr_ent        = '{id: s_node_id, bidir: s_link_bidir, known: s_coord_known,
                             x: s_coord_x, y: s_coord_y};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vbits_reg <= '0;
        end else if (tbl_we) begin
            vbits_reg[tbl_waddr] <= 1'b1;
        end
    end

    // ---------------- issue stage ----------------
    logic [FEED_W-1:0] feed_reg;
    logic              issue_reg;
    logic [FEED_W-1:0] feed_ent;
    logic [IDX_W-1:0]  tbl_raddr;
    logic [ENT_W-1:0]  tbl_rdata;
    tag_t              a_tag;

    assign feed_ent  = feed_reg - FEED_W'(2);
    assign tbl_raddr = feed_ent[IDX_W-1:0];

    always_comb begin
        a_tag.vld  = issue_reg;
        a_tag.last = (feed_reg == FEED_W'(NEIGHBORS + 1));
        if (feed_reg == FEED_W'(0)) begin
            a_tag.kind = PT_OWN;
        end else if (feed_reg == FEED_W'(1)) begin
            a_tag.kind = PT_FACE;
        end else begin
            a_tag.kind = PT_ENTRY;
        end
    end

    ggnh_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NEIGHBORS)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (wr_ent),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // ---------------- stage b: ram data ----------------
    tag_t b_tag_reg;
    logic b_ent_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_tag_reg <= '0;
        end else begin
            b_tag_reg <= a_tag;
        end
        b_ent_ok_reg <= vbits_reg[tbl_raddr];
    end

    // ---------------- stage c: point select, abs diff ----------------
    entry_t                       rd_ent;
    logic signed [COORD_BITS-1:0] px, py;
    logic [ABS_W-1:0]             dxu, dyu;
    logic [ABS_W-1:0]             ax_next, ay_next;

    tag_t             c_tag_reg;
    logic [ABS_W-1:0] c_ax_reg, c_ay_reg;
    logic [15:0]      c_id_reg;
    logic             c_bidir_reg, c_known_reg;

    // a slot never written since reset reads as an empty entry
    assign rd_ent = b_ent_ok_reg ? entry_t'(tbl_rdata) : '0;

    always_comb begin
        case (b_tag_reg.kind)
            PT_OWN: begin
                px = own_x_reg;
                py = own_y_reg;
            end
            PT_FACE: begin
                px = face_x_reg;
                py = face_y_reg;
            end
            default: begin
                px = rd_ent.x;
                py = rd_ent.y;
            end
        endcase
        dxu     = {dst_x_reg[COORD_BITS-1], dst_x_reg} - {px[COORD_BITS-1], px};
        dyu     = {dst_y_reg[COORD_BITS-1], dst_y_reg} - {py[COORD_BITS-1], py};
        ax_next = dxu[ABS_W-1] ? (~dxu + 1'b1) : dxu;
        ay_next = dyu[ABS_W-1] ? (~dyu + 1'b1) : dyu;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_tag_reg <= '0;
        end else begin
            c_tag_reg <= b_tag_reg;
        end
        c_ax_reg    <= ax_next;
        c_ay_reg    <= ay_next;
        c_id_reg    <= rd_ent.id;
        c_bidir_reg <= rd_ent.bidir;
        c_known_reg <= rd_ent.known;
    end

    // ---------------- stage d: squares ----------------
    tag_t              d_tag_reg;
    logic [DIST_W-1:0] d_sqx_reg, d_sqy_reg;
    logic [15:0]       d_id_reg;
    logic              d_bidir_reg, d_known_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_tag_reg <= '0;
        end else begin
            d_tag_reg <= c_tag_reg;
        end
        d_sqx_reg   <= DIST_W'(c_ax_reg) * DIST_W'(c_ax_reg);
        d_sqy_reg   <= DIST_W'(c_ay_reg) * DIST_W'(c_ay_reg);
        d_id_reg    <= c_id_reg;
        d_bidir_reg <= c_bidir_reg;
        d_known_reg <= c_known_reg;
    end

    // ---------------- stage e: distance ----------------
    tag_t              e_tag_reg;
    logic [DIST_W-1:0] e_dist_reg;
    logic [15:0]       e_id_reg;
    logic              e_bidir_reg, e_known_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_tag_reg <= '0;
        end else begin
            e_tag_reg <= d_tag_reg;
        end
        e_dist_reg  <= d_sqx_reg + d_sqy_reg;
        e_id_reg    <= d_id_reg;
        e_bidir_reg <= d_bidir_reg;
        e_known_reg <= d_known_reg;
    end

    // ---------------- decision ----------------
    logic [DIST_W-1:0] own_d_reg;
    logic [DIST_W-1:0] best_reg;
    logic [15:0]       hop_reg;
    logic              greedy_reg;
    logic              found_reg;
    logic              scan_end;

    assign scan_end = e_tag_reg.vld && e_tag_reg.last;

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            hop_reg   <= ADDR_BCAST;
            found_reg <= 1'b0;
        end else if (e_tag_reg.vld) begin
            case (e_tag_reg.kind)
                PT_OWN: begin
                    own_d_reg <= e_dist_reg;
                    best_reg  <= e_dist_reg;
                end
                PT_FACE: begin
                    greedy_reg <= (face_id_reg == ADDR_BCAST) || (own_d_reg < e_dist_reg);
                end
                default: begin
                    // a bidirectional destination neighbor wins; later entries are ignored
                    if (greedy_reg && !found_reg && e_bidir_reg) begin
                        if (e_id_reg == dst_id_reg) begin
                            hop_reg   <= e_id_reg;
                            found_reg <= 1'b1;
                        end else if (e_known_reg && (e_dist_reg < best_reg)) begin
                            best_reg <= e_dist_reg;
                            hop_reg  <= e_id_reg;
                        end
                    end
                end
            endcase
        end
    end

    // ---------------- state machine ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_action == ACT_ROUTE && s_coord_known) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            issue_reg <= 1'b0;
            feed_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (in_acc && s_action == ACT_ROUTE && s_coord_known) begin
                issue_reg <= 1'b1;
                feed_reg  <= '0;
            end else if (issue_reg) begin
                if (a_tag.last) begin
                    issue_reg <= 1'b0;
                end
                feed_reg <= feed_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            dst_id_reg  <= s_node_id;
            dst_x_reg   <= s_coord_x;
            dst_y_reg   <= s_coord_y;
            face_id_reg <= s_face_start_id;
            face_x_reg  <= s_face_x;
            face_y_reg  <= s_face_y;
            if (s_action == ACT_WRITE) begin
                res_kind_reg <= RES_WRITE;
            end else if (!s_coord_known) begin
                res_kind_reg <= RES_BADADDR;
            end else begin
                res_kind_reg <= RES_ROUTE;
            end
        end
    end

    // ---------------- result register ----------------
    logic        m_valid_reg;
    logic [1:0]  m_status_reg, m_status_next;
    logic [15:0] m_hop_reg, m_hop_next;
    logic [15:0] m_face_reg, m_face_next;

    always_comb begin
        case (res_kind_reg)
            RES_WRITE: begin
                m_status_next = ST_WRITTEN;
                m_hop_next    = ADDR_BCAST;
                m_face_next   = ADDR_BCAST;
            end
            RES_BADADDR: begin
                m_status_next = ST_BADADDR;
                m_hop_next    = ADDR_BCAST;
                m_face_next   = face_id_reg;
            end
            default: begin
                if (hop_reg == ADDR_BCAST) begin
                    // failed greedy scan restarts the face at this node; otherwise the face start is passed on
                    m_status_next = ST_NOROUTE;
                    m_hop_next    = ADDR_BCAST;
                    m_face_next   = greedy_reg ? own_id_reg : face_id_reg;
                end else begin
                    m_status_next = ST_FWD;
                    m_hop_next    = hop_reg;
                    m_face_next   = ADDR_BCAST;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_status_reg <= m_status_next;
            m_hop_reg    <= m_hop_next;
            m_face_reg   <= m_face_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_next_hop       = m_hop_reg;
    assign m_face_start_out = m_face_reg;

    // ---------------- assertions ----------------
    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word accepted while one is in work");

    a_fwd_word_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FWD) |->
            (m_next_hop != ADDR_BCAST && m_face_start_out == ADDR_BCAST))
        else $error("forwarded result without a hop or with a face start");

    a_pipe_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        e_tag_reg.vld |-> (state_reg == S_SCAN))
        else $error("distance pipeline active outside the scan");

    a_finish_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_valid && state_reg == S_IDLE))
        else $error("finished result not presented");

endmodule

`default_nettype wire
